// ===== rtl/core/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared widths, command codes and rule constants for the life grid step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

   // default grid size
   localparam int DEF_ROWS = 16;
   localparam int DEF_COLS = 16;

   // request field widths
   localparam int CMD_W = 2;
   localparam int ROW_W = 4;
   localparam int COL_W = 4;

   // width that holds any row or column index up to the largest grid (64)
   localparam int IDX_W = 7;

   // neighbor count width (0..8)
   localparam int NBR_W = 4;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVOLVE = 2'd2;

   // B3/S23 rule
   localparam logic [NBR_W-1:0] NBR_BIRTH   = 4'd3;
   localparam logic [NBR_W-1:0] NBR_SURVIVE = 4'd2;

endpackage

`default_nettype wire

// ===== rtl/core/lgs_ram.sv =====
// ----------------------------------------------------------------------------
// lgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lgs_row_unit.sv =====
// ----------------------------------------------------------------------------
// lgs_row_unit
// Next-generation row from three old rows; border columns keep their value.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_row_unit
   import lgs_pkg::*;
#(
   parameter int COLS = DEF_COLS
) (
   input  wire logic [COLS-1:0] above,
   input  wire logic [COLS-1:0] center,
   input  wire logic [COLS-1:0] below,
   output logic      [COLS-1:0] next_row
);

   // border columns pass through
   assign next_row[0]      = center[0];
   assign next_row[COLS-1] = center[COLS-1];

   for (genvar c = 1; c < COLS - 1; c++) begin : g_lane
      logic [NBR_W-1:0] nbr;

      assign nbr = NBR_W'(above[c-1]) + NBR_W'(above[c]) + NBR_W'(above[c+1])
                 + NBR_W'(center[c-1]) + NBR_W'(center[c+1])
                 + NBR_W'(below[c-1]) + NBR_W'(below[c]) + NBR_W'(below[c+1]);

      assign next_row[c] = (nbr == NBR_BIRTH) || (center[c] && (nbr == NBR_SURVIVE));
   end

endmodule

`default_nettype wire

// ===== rtl/core/life_grid_generation_step_unit.sv =====
// ----------------------------------------------------------------------------
// life_grid_generation_step_unit
// Cell grid with write, read and B3/S23 evolve commands over a row RAM.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  req     | req_valid/ready, command, row, col, cell_in    | in
//  rsp     | rsp_valid/ready, cell_value, command_done      | out
//
//  Write and read step through accept, one RAM row access (read-modify-write
//  for a write) and result load.
//  Evolve sweeps the grid: it reads one row per cycle through the
//  single RAM read port and writes one updated row per cycle behind it.
//  Reset clears per-row valid bits at once; no clearing pass is needed.
//  A waiting output result does not block the next request, only that request's result load.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_generation_step_unit
   import lgs_pkg::*;
#(
   parameter int ROWS = DEF_ROWS,
   parameter int COLS = DEF_COLS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [CMD_W-1:0] req_command,
   input  wire logic [ROW_W-1:0] req_row,
   input  wire logic [COL_W-1:0] req_col,
   input  wire logic             req_cell_in,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_cell_value,
   output logic [CMD_W-1:0]      rsp_command_done
);

   localparam int RowAw = $clog2(ROWS);
   localparam int ColAw = $clog2(COLS);
   localparam int CntW  = $clog2(ROWS + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CELL  = 4'b0010,
      S_SWEEP = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [RowAw-1:0] row_addr_ff, row_addr_in;
   logic [ColAw-1:0] col_idx_ff, col_idx_in;
   logic             cell_in_ff, cell_in_in;
   logic             inside_ff, inside_in;
   logic             res_cell_ff, res_cell_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [COLS-1:0]  top_ff, top_in;
   logic [COLS-1:0]  mid_ff, mid_in;
   logic [ROWS-1:0]  row_valid_ff, row_valid_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_cell_value_ff, rsp_cell_value_in;
   logic [CMD_W-1:0] rsp_command_done_ff, rsp_command_done_in;

   logic             accept;
   logic [IDX_W-1:0] req_row_ext;
   logic [IDX_W-1:0] req_col_ext;
   logic             req_inside;
   logic             ram_we;
   logic [RowAw-1:0] ram_waddr;
   logic [COLS-1:0]  ram_wdata;
   logic [RowAw-1:0] ram_raddr;
   logic [COLS-1:0]  ram_rdata;
   logic [COLS-1:0]  row_data;
   logic [COLS-1:0]  patched_row;
   logic [COLS-1:0]  evolved_row;
   logic [CntW-1:0]  sweep_waddr;
   logic             rsp_load;

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign req_row_ext = IDX_W'(req_row);
   assign req_col_ext = IDX_W'(req_col);
   assign req_inside  = (req_row_ext < IDX_W'(ROWS)) && (req_col_ext < IDX_W'(COLS));

   // rows never written read as dead
   assign row_data = rd_vld_ff ? ram_rdata : '0;

   always_comb begin
      patched_row              = row_data;
      patched_row[col_idx_ff]  = cell_in_ff;
   end

   // sweep writes the row one behind the one arriving from the RAM
   assign sweep_waddr = cnt_ff - CntW'(2);

   lgs_ram #(
      .WIDTH (COLS),
      .DEPTH (ROWS)
   ) u_grid_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   lgs_row_unit #(
      .COLS (COLS)
   ) u_row_unit (
      .above    (top_ff),
      .center   (mid_ff),
      .below    (row_data),
      .next_row (evolved_row)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      row_addr_in  = row_addr_ff;
      col_idx_in   = col_idx_ff;
      cell_in_in   = cell_in_ff;
      inside_in    = inside_ff;
      res_cell_in  = res_cell_ff;
      cnt_in       = cnt_ff;
      top_in       = top_ff;
      mid_in       = mid_ff;
      ram_we       = 1'b0;
      ram_waddr    = row_addr_ff;
      ram_wdata    = patched_row;
      ram_raddr    = '0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_inside) begin
               ram_raddr = req_row_ext[RowAw-1:0];
            end
            if (accept) begin
               cmd_in      = req_command;
               row_addr_in = req_row_ext[RowAw-1:0];
               col_idx_in  = req_col_ext[ColAw-1:0];
               cell_in_in  = req_cell_in;
               inside_in   = req_inside;
               res_cell_in = 1'b0;
               cnt_in      = '0;
               unique case (req_command)
                  CMD_WRITE, CMD_READ: state_in = S_CELL;
                  CMD_EVOLVE:          state_in = S_SWEEP;
                  default:             state_in = S_DONE;
               endcase
            end
         end
         S_CELL: begin
            ram_raddr = row_addr_ff;
            if (cmd_ff == CMD_READ) begin
               res_cell_in = inside_ff && row_data[col_idx_ff];
            end else begin
               ram_we = inside_ff;
            end
            state_in = S_DONE;
         end
         S_SWEEP: begin
            if (cnt_ff < CntW'(ROWS)) begin
               ram_raddr = cnt_ff[RowAw-1:0];
            end
            cnt_in = cnt_ff + CntW'(1);
            // shift the row window once read data arrives
            if (cnt_ff != '0) begin
               top_in = top_ff;
               top_in = mid_ff;
               mid_in = row_data;
            end
            // window full from the third arriving row on
            if (cnt_ff >= CntW'(3)) begin
               ram_we    = 1'b1;
               ram_waddr = sweep_waddr[RowAw-1:0];
               ram_wdata = evolved_row;
            end
            if (cnt_ff == CntW'(ROWS)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (ram_we) begin
         row_valid_in[ram_waddr] = 1'b1;
      end
   end

   assign rd_vld_in = row_valid_ff[ram_raddr];

   always_comb begin
      rsp_cell_value_in   = rsp_cell_value_ff;
      rsp_command_done_in = rsp_command_done_ff;
      if (rsp_load) begin
         rsp_valid_in        = 1'b1;
         rsp_cell_value_in   = res_cell_ff;
         rsp_command_done_in = cmd_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff              <= cmd_in;
      row_addr_ff         <= row_addr_in;
      col_idx_ff          <= col_idx_in;
      cell_in_ff          <= cell_in_in;
      inside_ff           <= inside_in;
      res_cell_ff         <= res_cell_in;
      cnt_ff              <= cnt_in;
      top_ff              <= top_in;
      mid_ff              <= mid_in;
      rsp_cell_value_ff   <= rsp_cell_value_in;
      rsp_command_done_ff <= rsp_command_done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_value   = rsp_cell_value_ff;
   assign rsp_command_done = rsp_command_done_ff;

`ifndef SYNTHESIS
   a_we_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CELL || state_ff == S_SWEEP))
      else $error("grid write outside cell or sweep state");

   a_sweep_interior: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == S_SWEEP) |->
         (ram_waddr != '0 && ram_waddr != RowAw'(ROWS - 1)))
      else $error("evolve wrote a border row");

   a_sweep_no_collide: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == S_SWEEP) |-> (ram_waddr != ram_raddr))
      else $error("sweep read and write hit the same row");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside done state");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (row_valid_ff == '0 && !rsp_valid_ff))
      else $error("grid not cleared by reset");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the life grid step unit: directed cell access and
// generation-rule cases, output back-pressure, then random grid traffic, all
// checked result by result against an in-bench model of the B3/S23 grid.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
   import lgs_pkg::*;
();

   localparam int GRID_ROWS = DEF_ROWS;
   localparam int GRID_COLS = DEF_COLS;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 700;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic             cell_value;
      logic [CMD_W-1:0] command_done;
   } step_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [CMD_W-1:0] req_command = CMD_WRITE;
   logic [ROW_W-1:0] req_row = '0;
   logic [COL_W-1:0] req_col = '0;
   logic             req_cell_in = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_cell_value;
   logic [CMD_W-1:0] rsp_command_done;

   logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
   step_result_type      pending_results [$];
   int                   error_count = 0;
   int                   burst_left = 0;
   bit                   paced_bursts = 1'b1;
   bit                   hold_request = 1'b0;
   int                   idle_cycles = 0;

   life_grid_generation_step_unit #(
      .ROWS(GRID_ROWS),
      .COLS(GRID_COLS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_cell_in     (req_cell_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_command_done(rsp_command_done)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // one B3/S23 generation over the interior, counted from the old grid
   task automatic advance_generation();
      logic [GRID_COLS-1:0] prev [GRID_ROWS];
      int n;
      prev = life_grid;
      for (int r = 1; r < GRID_ROWS - 1; r++) begin
         for (int c = 1; c < GRID_COLS - 1; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr != 0 || dc != 0) n += prev[r + dr][c + dc];
               end
            end
            if (prev[r][c]) life_grid[r][c] = (n == NBR_SURVIVE || n == NBR_BIRTH);
            else life_grid[r][c] = (n == NBR_BIRTH);
         end
      end
   endtask

   task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                                input logic [COL_W-1:0] col, input logic cell_bit);
      step_result_type res;
      bit in_grid;
      in_grid = (row < GRID_ROWS) && (col < GRID_COLS);
      res.cell_value = 1'b0;
      res.command_done = cmd;
      case (cmd)
         CMD_WRITE: begin
            if (in_grid) life_grid[row][col] = cell_bit;
         end
         CMD_READ: begin
            if (in_grid) res.cell_value = life_grid[row][col];
         end
         CMD_EVOLVE: begin
            advance_generation();
         end
         default: begin
         end
      endcase
      pending_results.push_back(res);
   endtask

   // offer one request; between bursts, drop valid for a random gap
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                               input logic [COL_W-1:0] col, input logic cell_bit);
      int gap;
      if (paced_bursts && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 30);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_row <= row;
      req_col <= col;
      req_cell_in <= cell_bit;
      do @(posedge clock); while (!req_ready);
      apply_command(cmd, row, col, cell_bit);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      step_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, command_done", rsp_command_done, -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_command_done !== want.command_done)
               report_mismatch("command_done", rsp_command_done, want.command_done);
            if (rsp_cell_value !== want.cell_value)
               report_mismatch("cell_value", rsp_cell_value, want.cell_value);
         end
      end
   end

   // receiver: ready pattern changes every stretch; long hold-off on request
   initial begin
      int mode;
      int span;
      while (reset) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 96);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            if (hold_request) begin
               hold_request = 1'b0;
               rsp_ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES - 1) begin
                  @(negedge clock);
                  rsp_ready <= 1'b0;
               end
            end else begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 3) != 0);
                  2: rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= ((k % 8) < 3);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic test_cell_access();
      send_request(CMD_WRITE, 4'd0, 4'd0, 1'b1);
      send_request(CMD_WRITE, 4'd15, 4'd15, 1'b1);
      send_request(CMD_WRITE, 4'd0, 4'd15, 1'b1);
      send_request(CMD_WRITE, 4'd15, 4'd0, 1'b1);
      send_request(CMD_READ, 4'd0, 4'd0, 1'b0);
      send_request(CMD_READ, 4'd15, 4'd15, 1'b1);
      send_request(CMD_READ, 4'd7, 4'd9, 1'b0);
      send_request(CMD_WRITE, 4'd0, 4'd0, 1'b0);
      send_request(CMD_READ, 4'd0, 4'd0, 1'b1);
      // unused command code: grid untouched, echo comes back
      send_request(CMD_UNUSED, 4'd15, 4'd15, 1'b1);
      send_request(CMD_READ, 4'd0, 4'd15, 1'b0);
   endtask

   task automatic test_generation_rules();
      // L of three cells gives a birth at (2,2); a lone cell dies
      send_request(CMD_WRITE, 4'd1, 4'd1, 1'b1);
      send_request(CMD_WRITE, 4'd1, 4'd2, 1'b1);
      send_request(CMD_WRITE, 4'd2, 4'd1, 1'b1);
      send_request(CMD_WRITE, 4'd8, 4'd8, 1'b1);
      send_request(CMD_EVOLVE, 4'd15, 4'd15, 1'b1);
      send_request(CMD_READ, 4'd2, 4'd2, 1'b0);
      send_request(CMD_READ, 4'd1, 4'd1, 1'b0);
      send_request(CMD_READ, 4'd8, 4'd8, 1'b0);
      send_request(CMD_READ, 4'd15, 4'd15, 1'b0);
      // the block that formed is stable, the borders hold
      send_request(CMD_EVOLVE, 4'd0, 4'd0, 1'b0);
      send_request(CMD_READ, 4'd2, 4'd2, 1'b0);
      send_request(CMD_READ, 4'd15, 4'd0, 1'b0);
   endtask

   task automatic test_output_backpressure();
      paced_bursts = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 16; i++) begin
         send_request(($urandom_range(0, 2) == 2) ? CMD_EVOLVE : CMD_READ,
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
      end
      paced_bursts = 1'b1;
   endtask

   // rounds of seeding a window, then evolving and reading it, plus noise
   task automatic test_random_traffic();
      int sent;
      int density;
      int r0;
      int c0;
      int span;
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         density = $urandom_range(20, 70);
         r0 = $urandom_range(0, 10);
         c0 = $urandom_range(0, 10);
         span = $urandom_range(3, 6);
         repeat ($urandom_range(12, 36)) begin
            send_request(CMD_WRITE, 4'(r0 + $urandom_range(0, span - 1)),
                         4'(c0 + $urandom_range(0, span - 1)),
                         ($urandom_range(0, 99) < density));
            sent++;
         end
         repeat ($urandom_range(1, 4)) begin
            send_request(CMD_EVOLVE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)));
            sent++;
            repeat ($urandom_range(2, 6)) begin
               send_request(CMD_READ, 4'(r0 + $urandom_range(0, span - 1)),
                            4'(c0 + $urandom_range(0, span - 1)), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
         repeat ($urandom_range(0, 4)) begin
            send_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int r = 0; r < GRID_ROWS; r++) life_grid[r] = '0;
      test_cell_access();
      test_generation_rules();
      test_output_backpressure();
      test_random_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (GRID_ROWS + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
